/* rtl/core/ptle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ptle_pkg;

    localparam int ID_W   = 7;
    localparam int LIFE_W = 2;
    localparam int CODE_W = 16;

    typedef enum logic [1:0] {
        FN_FORK = 2'd0,
        FN_EXIT = 2'd1,
        FN_WAIT = 2'd2,
        FN_KILL = 2'd3
    } func_t;

    localparam logic [LIFE_W-1:0] LIFE_RUNNING    = 2'd0;
    localparam logic [LIFE_W-1:0] LIFE_WAITING    = 2'd1;
    localparam logic [LIFE_W-1:0] LIFE_ZOMBIE     = 2'd2;
    localparam logic [LIFE_W-1:0] LIFE_TERMINATED = 2'd3;

    localparam logic [ID_W-1:0]   FIRST_ID  = 7'd1;
    localparam logic [ID_W-1:0]   SECOND_ID = 7'd2;
    localparam logic signed [7:0] ANY_CHILD = -8'sd1;
    localparam logic [CODE_W-1:0] KILL_CODE = 16'hFFFF;

    typedef struct packed {
        logic [1:0]               func;
        logic [ID_W-1:0]          parent_id;
        logic [ID_W-1:0]          target_id;
        logic signed [7:0]        child_id;
        logic signed [CODE_W-1:0] exit_code;
    } cmd_t;

    typedef struct packed {
        logic                     applied;
        logic                     row_valid;
        logic [ID_W-1:0]          row_id;
        logic [ID_W-1:0]          row_parent;
        logic [LIFE_W-1:0]        row_state;
        logic signed [CODE_W-1:0] row_code;
        logic                     last;
    } rpt_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   parent;
        logic [LIFE_W-1:0] life;
        logic [CODE_W-1:0] code;
    } entry_t;

endpackage

`default_nettype wire

/* rtl/core/process_table_lifecycle_engine_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake              Payload      Beat
// cmd      cmd_valid/cmd_ready    ptle cmd_t   one command (fork/exit/wait/kill)
// rpt      rpt_valid/rpt_ready    ptle rpt_t   one table row or one status beat
//
// One command at a time. Exit, kill and wait scan the table at one entry per
// cycle through the single read port; the report then streams at most one live
// row per cycle while rpt_ready keeps up. Fork skips the scan. After reset, the
// ST_INIT state writes entry 0 before cmd_ready rises. The output register lets
// the next command be taken while the final beat still waits; a stalled
// rpt_ready holds the report.
module process_table_lifecycle_engine_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output      logic           cmd_ready,
    input  wire ptle_pkg::cmd_t cmd,
    output      logic           rpt_valid,
    input  wire logic           rpt_ready,
    output      ptle_pkg::rpt_t rpt
);
    import ptle_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SRCH,
        ST_RPT,
        ST_ONE
    } state_t;

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [CW-1:0]   count_reg, count_next;     // entries in use
    logic [ID_W-1:0] next_id_reg, next_id_next;
    logic [CW-1:0]   live_reg, live_next;       // entries not terminated
    logic [CW-1:0]   idx_reg, idx_next;         // read pointer
    logic            dv_reg, dv_next;           // read data holds a fresh entry
    logic [IW-1:0]   didx_reg, didx_next;       // index of that entry
    logic [CW-1:0]   sent_reg, sent_next;       // rows already sent
    logic            one_applied_reg, one_applied_next;
    rpt_t            out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic            we;
    logic [IW-1:0]   waddr;
    entry_t          wdata;
    logic            re;
    entry_t          rd;

    logic            slot_free;
    logic            hit;
    logic            any_child;
    logic            keep;
    logic            consume;
    logic            last_row;
    entry_t          mod;

    ptle_table #(
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rd)
    );

    assign slot_free = !out_valid_reg || rpt_ready;
    assign any_child = (cmd_reg.child_id == ANY_CHILD);

    // Match test on the entry just read
    always_comb
    begin
        hit = 1'b0;
        mod = rd;
        if (cmd_reg.func == FN_WAIT)
        begin
            hit = (rd.parent == cmd_reg.parent_id) && (rd.life == LIFE_ZOMBIE) &&
                  (any_child || (!cmd_reg.child_id[7] && rd.id == cmd_reg.child_id[6:0]));
            mod.life = LIFE_TERMINATED;
        end
        else
        begin
            hit = (rd.id == cmd_reg.target_id) && (rd.life != LIFE_TERMINATED);
            mod.life = LIFE_ZOMBIE;
            mod.code = (cmd_reg.func == FN_EXIT) ? cmd_reg.exit_code : KILL_CODE;
        end
    end

    assign keep     = (rd.life != LIFE_TERMINATED);
    assign consume  = dv_reg && (!keep || slot_free);
    assign last_row = (sent_reg == live_reg - CW'(1));

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        count_next       = count_reg;
        next_id_next     = next_id_reg;
        live_next        = live_reg;
        idx_next         = idx_reg;
        dv_next          = dv_reg;
        didx_next        = didx_reg;
        sent_next        = sent_reg;
        one_applied_next = one_applied_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;
        we               = 1'b0;
        waddr            = '0;
        wdata            = '0;
        re               = 1'b0;

        if (out_valid_reg && rpt_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                we         = 1'b1;
                wdata.id   = FIRST_ID;
                wdata.life = LIFE_RUNNING;
                state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next  = cmd;
                    idx_next  = '0;
                    dv_next   = 1'b0;
                    sent_next = '0;
                    if (cmd.func == FN_FORK)
                    begin
                        if (count_reg < CW'(TABLE_DEPTH))
                        begin
                            we           = 1'b1;
                            waddr        = count_reg[IW-1:0];
                            wdata.id     = next_id_reg;
                            wdata.parent = cmd.parent_id;
                            wdata.life   = LIFE_RUNNING;
                            count_next   = count_reg + CW'(1);
                            next_id_next = next_id_reg + ID_W'(1);
                            live_next    = live_reg + CW'(1);
                            state_next   = ST_RPT;
                        end
                        else
                        begin
                            one_applied_next = 1'b0;
                            state_next       = ST_ONE;
                        end
                    end
                    else
                    begin
                        state_next = ST_SRCH;
                    end
                end
            end

            ST_SRCH:
            begin
                // read ahead one entry a cycle, compare the one returned
                if (idx_reg < count_reg)
                begin
                    re        = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                    dv_next   = 1'b1;
                    didx_next = idx_reg[IW-1:0];
                end
                else
                begin
                    dv_next = 1'b0;
                end

                if (dv_reg && hit)
                begin
                    we         = 1'b1;
                    waddr      = didx_reg;
                    wdata      = mod;
                    idx_next   = '0;
                    dv_next    = 1'b0;
                    state_next = ST_RPT;
                    if (cmd_reg.func == FN_WAIT)
                    begin
                        live_next = live_reg - CW'(1);
                    end
                end
                else if (!dv_reg && idx_reg == count_reg)
                begin
                    one_applied_next = 1'b0;
                    state_next       = ST_ONE;
                end
            end

            ST_RPT:
            begin
                if (live_reg == '0)
                begin
                    one_applied_next = 1'b1;
                    state_next       = ST_ONE;
                end
                else
                begin
                    if (consume)
                    begin
                        dv_next = 1'b0;
                    end
                    if ((!dv_reg || consume) && idx_reg < count_reg)
                    begin
                        re       = 1'b1;
                        idx_next = idx_reg + CW'(1);
                        dv_next  = 1'b1;
                    end
                    if (dv_reg && keep && slot_free)
                    begin
                        out_next.applied    = 1'b1;
                        out_next.row_valid  = 1'b1;
                        out_next.row_id     = rd.id;
                        out_next.row_parent = rd.parent;
                        out_next.row_state  = rd.life;
                        out_next.row_code   = (rd.life == LIFE_ZOMBIE) ? rd.code : '0;
                        out_next.last       = last_row;
                        out_valid_next      = 1'b1;
                        sent_next           = sent_reg + CW'(1);
                        if (last_row)
                        begin
                            dv_next    = 1'b0;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_ONE:
            begin
                // status-only beat: no change, or nothing left alive
                if (slot_free)
                begin
                    out_next         = '0;
                    out_next.applied = one_applied_reg;
                    out_next.last    = 1'b1;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            cmd_reg         <= '0;
            count_reg       <= CW'(1);
            next_id_reg     <= SECOND_ID;
            live_reg        <= CW'(1);
            idx_reg         <= '0;
            dv_reg          <= 1'b0;
            didx_reg        <= '0;
            sent_reg        <= '0;
            one_applied_reg <= 1'b0;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            count_reg       <= count_next;
            next_id_reg     <= next_id_next;
            live_reg        <= live_next;
            idx_reg         <= idx_next;
            dv_reg          <= dv_next;
            didx_reg        <= didx_next;
            sent_reg        <= sent_next;
            one_applied_reg <= one_applied_next;
            out_reg         <= out_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign rpt_valid = out_valid_reg;
    assign rpt       = out_reg;

endmodule

`default_nettype wire

/* rtl/core/ptle_table.sv */
`timescale 1ns / 1ps
`default_nettype none

// Entry store: one write port, one read port, registered read data.
module ptle_table #(
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire ptle_pkg::entry_t         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      ptle_pkg::entry_t         rdata
);
    import ptle_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
